/* hdl/sas_pkg.sv */
`default_nettype none
package sas_pkg;
  localparam int MaxFrames = 64;
  localparam int PosBits = 6;
  localparam int TimeBits = 24;
  localparam int CntBits = 7;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_STEP  = 3'd1,
    MODE_PLAY  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_CLAMP = 3'd4
  } mode_t;

  localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
  localparam logic [2:0] REG_DEFAULT_DUR = 3'd1;
  localparam logic [2:0] REG_LOOP_ENABLE = 3'd2;
  localparam logic [2:0] REG_CELL_WIDTH  = 3'd3;
  localparam logic [2:0] REG_CELL_HEIGHT = 3'd4;
  localparam logic [2:0] REG_SHEET_COLS  = 3'd5;

  typedef struct packed {
    logic load;       // capture item, clear changed
    logic tbl_write;  // write frame table entry
    logic tbl_read;   // read table at position
    logic tick_add;   // add delta to elapsed
    logic tick_walk;  // one walk step
    logic step_init;  // position + delta
    logic div_step;   // one restoring division bit
    logic step_done;  // commit step result
    logic set_play;
    logic clamp;
    logic rect_start; // start cell / cols division
    logic out_load;   // register result
  } sas_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       walk_done;
    logic       div_done;
    logic       tick_skip;
  } sas_sts_t;
endpackage
`default_nettype wire

/* hdl/sas_ctrl.sv */
`default_nettype none
module sas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sas_pkg::sas_cmd_t      cmd,
  input  wire sas_pkg::sas_sts_t sts
);
  import sas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DISPATCH, S_TADD, S_TRD, S_TWALK, S_SDIV, S_RRD, S_RLD, S_RDIV, S_OUT,
    S_HOLD
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_RD:       cmd.tbl_read = 1'b1;
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_TICK:  cmd.tick_add = !sts.tick_skip;
          MODE_STEP:  cmd.step_init = 1'b1;
          MODE_PLAY:  cmd.set_play = 1'b1;
          MODE_WRITE: cmd.tbl_write = 1'b1;
          MODE_CLAMP: cmd.clamp = 1'b1;
          default: ;
        endcase
      end
      S_TADD:     cmd.tbl_read = 1'b1;
      S_TRD:      cmd.tbl_read = 1'b1;
      S_TWALK:    cmd.tick_walk = !sts.walk_done;
      S_SDIV:     begin
        cmd.div_step = !sts.div_done;
        cmd.step_done = sts.div_done;
      end
      S_RRD:      cmd.tbl_read = 1'b1;
      S_RLD:      cmd.rect_start = 1'b1;
      S_RDIV:     cmd.div_step = !sts.div_done;
      S_OUT:      cmd.out_load = 1'b1;
      S_HOLD:     ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:     if (in_valid) state <= S_RD;
        S_RD:       state <= S_DISPATCH;
        S_DISPATCH: begin
          if (sts.mode == MODE_TICK && !sts.tick_skip) state <= S_TADD;
          else if (sts.mode == MODE_STEP) state <= S_SDIV;
          else state <= S_RRD;
        end
        S_TADD:     state <= S_TRD;
        S_TRD:      state <= S_TWALK;
        S_TWALK:    state <= sts.walk_done ? S_RRD : S_TRD;
        S_SDIV:     if (sts.div_done) state <= S_RRD;
        S_RRD:      state <= S_RLD;
        S_RLD:      state <= S_RDIV;
        S_RDIV:     if (sts.div_done) state <= S_OUT;
        S_OUT:      begin
          if (!out_valid || !out_stall) state <= S_IDLE;
          else state <= S_HOLD;
        end
        S_HOLD:     if (!out_stall) state <= S_OUT;
        default:    state <= S_IDLE;
      endcase
    end
  end

  // out_load only takes effect when the output register is free
endmodule
`default_nettype wire

/* hdl/sas_dpath.sv */
`default_nettype none
module sas_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sas_pkg::sas_cmd_t            cmd,
  output sas_pkg::sas_sts_t                 sts,
  input  wire logic                         out_free,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [23:0]                  cfg_data,
  input  wire logic [2:0]                   mode,
  input  wire logic [23:0]                  delta_time,
  input  wire logic signed [15:0]           step_delta,
  input  wire logic                         play_flag,
  input  wire logic [5:0]                   entry_slot,
  input  wire logic signed [12:0]           entry_cell,
  input  wire logic [23:0]                  entry_duration,
  output logic [5:0]                        frame_position,
  output logic                              frame_changed,
  output logic                              is_playing,
  output logic                              rect_valid,
  output logic [23:0]                       rect_x,
  output logic [23:0]                       rect_y,
  output logic [11:0]                       rect_w,
  output logic [11:0]                       rect_h
);
  import sas_pkg::*;

  logic [CntBits-1:0]  frame_count;
  logic [TimeBits-1:0] default_duration;
  logic                loop_enable;
  logic [11:0]         cell_width, cell_height, sheet_columns;

  logic [12:0]         cell_table [MaxFrames];
  logic [TimeBits-1:0] hold_table [MaxFrames];
  logic [12:0]         rd_cell;
  logic [TimeBits-1:0] rd_hold;

  logic [PosBits-1:0]  play_position, before_pos;
  logic [31:0]         elapsed_time;
  logic                playing, changed;
  logic [2:0]          mode_q;
  logic [23:0]         dt_q;
  logic signed [15:0]  sd_q;
  logic                pf_q;
  logic [5:0]          slot_q;
  logic [12:0]         ecell_q;
  logic [23:0]         edur_q;
  logic [CntBits-1:0]  guard;
  logic                walk_stop;

  // shared restoring divider: 17-bit dividend, 12-bit divisor
  logic [16:0]         div_q;
  logic [12:0]         div_r;
  logic [11:0]         div_d;
  logic [4:0]          div_cnt;
  logic                div_neg;

  logic [CntBits-1:0]  count;
  logic [TimeBits-1:0] held;
  logic [CntBits-1:0]  pos_ext;
  logic [13:0]         div_trial;
  logic [11:0]         cols;
  logic [17:0]         step_sum;

  assign count = (frame_count > CntBits'(MaxFrames)) ? CntBits'(MaxFrames) : frame_count;
  assign held = (rd_hold != '0) ? rd_hold : default_duration;
  assign pos_ext = {1'b0, play_position};
  assign cols = (sheet_columns == '0) ? 12'd1 : sheet_columns;
  assign div_trial = {div_r, div_q[16]} - {2'b00, div_d};
  assign step_sum = 18'(signed'(sd_q)) + {12'd0, play_position};

  assign sts.mode = mode_q;
  assign sts.walk_done = walk_stop || held == '0 || elapsed_time < 32'(held)
                         || guard > count;
  assign sts.div_done = (div_cnt == '0);
  assign sts.tick_skip = !playing || count == '0 || held == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      default_duration <= '0;
      loop_enable <= 1'b1;
      cell_width <= '0;
      cell_height <= '0;
      sheet_columns <= 12'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_COUNT: frame_count <= cfg_data[CntBits-1:0];
        REG_DEFAULT_DUR: default_duration <= cfg_data[TimeBits-1:0];
        REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        REG_CELL_WIDTH:  cell_width <= cfg_data[11:0];
        REG_CELL_HEIGHT: cell_height <= cfg_data[11:0];
        REG_SHEET_COLS:  sheet_columns <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_write) begin
      cell_table[slot_q] <= ecell_q;
      hold_table[slot_q] <= edur_q[TimeBits-1:0];
    end
    if (cmd.tbl_read) begin
      rd_cell <= cell_table[play_position];
      rd_hold <= hold_table[play_position];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      dt_q <= delta_time;
      sd_q <= step_delta;
      pf_q <= play_flag;
      slot_q <= entry_slot;
      ecell_q <= entry_cell;
      edur_q <= entry_duration;
    end
    if (cmd.div_step) begin
      div_r <= div_trial[13] ? {div_r[11:0], div_q[16]} : div_trial[12:0];
      div_q <= {div_q[15:0], !div_trial[13]};
    end
    if (cmd.step_init) begin
      div_neg <= step_sum[17];
      div_q <= step_sum[17] ? 17'(-step_sum) : step_sum[16:0];
      div_r <= '0;
      div_d <= {5'd0, count};
    end
    if (cmd.rect_start) begin
      div_q <= {4'd0, rd_cell};
      div_r <= '0;
      div_d <= cols;
    end
    if (rst) begin
      play_position <= '0;
      elapsed_time <= '0;
      playing <= 1'b0;
      changed <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (cmd.div_step) div_cnt <= div_cnt - 5'd1;
      else if (cmd.step_init) div_cnt <= (count == '0) ? 5'd0 : 5'd17;
      else if (cmd.rect_start) div_cnt <= 5'd17;
      if (cmd.load) changed <= 1'b0;
      if (cmd.set_play) playing <= pf_q;
      if (cmd.clamp) begin
        if (count == '0) play_position <= '0;
        else if (pos_ext > count - 1'b1) play_position <= PosBits'(count - 1'b1);
      end
      if (cmd.tick_add) begin
        elapsed_time <= (elapsed_time > 32'hFFFF_FFFF - 32'(dt_q)) ? 32'hFFFF_FFFF
                        : elapsed_time + 32'(dt_q);
        before_pos <= play_position;
        guard <= '0;
        walk_stop <= 1'b0;
      end
      if (cmd.tick_walk) begin
        guard <= guard + 1'b1;
        if (pos_ext + 1'b1 < count) begin
          elapsed_time <= elapsed_time - 32'(held);
          play_position <= play_position + 1'b1;
          changed <= (play_position + 1'b1) != before_pos;
        end else if (loop_enable) begin
          elapsed_time <= elapsed_time - 32'(held);
          play_position <= '0;
          changed <= before_pos != '0;
        end else begin
          playing <= 1'b0;
          elapsed_time <= '0;
          walk_stop <= 1'b1;
        end
      end
      if (cmd.step_init) begin
        playing <= 1'b0;
        elapsed_time <= '0;
        if (count == '0) play_position <= '0;
      end
      if (cmd.step_done && count != '0) begin
        if (div_neg && div_r != '0) play_position <= PosBits'(13'(div_d) - div_r);
        else play_position <= PosBits'(div_r);
      end
    end
  end

  logic        rv;
  logic [23:0] rx_p, ry_p;
  assign rv = pos_ext < count && cell_width != '0 && cell_height != '0 && !rd_cell[12];
  assign rx_p = 24'(div_r[11:0] * cell_width);
  assign ry_p = 24'(div_q[11:0] * cell_height);

  always_ff @(posedge clk) begin
    if (cmd.out_load && out_free) begin
      frame_position <= play_position;
      frame_changed <= changed && mode_q == MODE_TICK;
      is_playing <= playing;
      rect_valid <= rv;
      rect_x <= rv ? rx_p : '0;
      rect_y <= rv ? ry_p : '0;
      rect_w <= rv ? cell_width : '0;
      rect_h <= rv ? cell_height : '0;
    end
  end
endmodule
`default_nettype wire

/* hdl/sprite_animation_sequencer_unit.sv */
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   mode .. entry_duration
// out       output     out_valid / out_stall frame_position .. rect_h
// cfg       input      cfg_we                cfg_index, cfg_data
// An item is taken only while the unit is idle, so it completes before the next
// is taken; a running tick walks at most count+1 frames, and a step and every
// result rectangle go through the bit-serial divider.
// The frame walk loop and the shared bit-serial divider set an item's duration.
// Reset: synchronous, clears state and config; frame table and output data stay.
// A stalled result holds; the next item may be taken and waits at the output.
`default_nettype none
module sprite_animation_sequencer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         mode,
  input  wire logic [23:0]        delta_time,
  input  wire logic signed [15:0] step_delta,
  input  wire logic               play_flag,
  input  wire logic [5:0]         entry_slot,
  input  wire logic signed [12:0] entry_cell,
  input  wire logic [23:0]        entry_duration,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              frame_position,
  output logic                    frame_changed,
  output logic                    is_playing,
  output logic                    rect_valid,
  output logic [23:0]             rect_x,
  output logic [23:0]             rect_y,
  output logic [11:0]             rect_w,
  output logic [11:0]             rect_h
);
  import sas_pkg::*;

  sas_cmd_t cmd;
  sas_sts_t sts;

  sas_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  sas_dpath u_dpath (
    .clk, .rst, .cmd, .sts, .out_free(!out_valid || !out_stall),
    .cfg_we, .cfg_index, .cfg_data,
    .mode, .delta_time, .step_delta, .play_flag, .entry_slot, .entry_cell, .entry_duration,
    .frame_position, .frame_changed, .is_playing, .rect_valid,
    .rect_x, .rect_y, .rect_w, .rect_h
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("accepted while busy");
  a_empty_rect: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rect_valid |-> rect_w == '0 && rect_x == '0) else $error("rect not empty");
  a_changed_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.step_init |-> !cmd.tick_walk) else $error("step and walk together");
endmodule
`default_nettype wire

/* tb/sv/tb_sprite_animation_sequencer_unit.sv */
`timescale 1ns / 100ps
module tb_sprite_animation_sequencer_unit;
  import sas_pkg::*;

  typedef struct {
    logic [2:0]         mode;
    logic [23:0]        delta_time;
    logic signed [15:0] step_delta;
    logic               play_flag;
    logic [5:0]         entry_slot;
    logic signed [12:0] entry_cell;
    logic [23:0]        entry_duration;
  } anim_cmd_t;

  typedef struct {
    logic [5:0]  frame_position;
    logic        frame_changed;
    logic        is_playing;
    logic        rect_valid;
    logic [23:0] rect_x;
    logic [23:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
  } frame_view_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [2:0] mode = '0;
  logic [23:0] delta_time = '0;
  logic signed [15:0] step_delta = '0;
  logic play_flag = 0;
  logic [5:0] entry_slot = '0;
  logic signed [12:0] entry_cell = '0;
  logic [23:0] entry_duration = '0;
  logic out_valid, out_stall = 0;
  logic [5:0] frame_position;
  logic frame_changed, is_playing, rect_valid;
  logic [23:0] rect_x, rect_y;
  logic [11:0] rect_w, rect_h;

  sprite_animation_sequencer_unit u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // mirrored registers and player state
  logic [6:0]  m_count;
  logic [23:0] m_dflt;
  logic        m_loop;
  logic [11:0] m_cw, m_ch, m_cols;
  logic [5:0]  s_pos;
  logic [31:0] s_elapsed;
  logic        s_playing;
  logic [12:0] s_cell [MaxFrames];
  logic [23:0] s_hold [MaxFrames];

  anim_cmd_t   pending_cmds[$];
  frame_view_t expected_views[$];
  int errors = 0, n_accepted = 0, n_checked = 0, n_ticks_moved = 0;

  function automatic void queue_cmd(anim_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic logic [23:0] hold_at(logic [5:0] p);
    return s_hold[p] != 0 ? s_hold[p] : m_dflt;
  endfunction

  function automatic void advance_player(anim_cmd_t c);
    frame_view_t v;
    int cnt, nxt, g;
    logic [5:0] prev;
    logic [31:0] cols, cell_idx, hd;
    cnt = (m_count > MaxFrames) ? MaxFrames : m_count;
    v = '{default: '0};
    case (c.mode)
      MODE_TICK: begin
        prev = s_pos;
        if (s_playing && cnt != 0 && hold_at(s_pos) != 0) begin
          s_elapsed = (s_elapsed > 32'hFFFF_FFFF - c.delta_time) ? 32'hFFFF_FFFF
                      : s_elapsed + c.delta_time;
          for (g = 0; g <= cnt; g++) begin
            hd = hold_at(s_pos);
            if (hd == 0 || s_elapsed < hd) break;
            s_elapsed -= hd;
            if (s_pos + 1 < cnt) s_pos++;
            else if (m_loop) s_pos = 0;
            else begin
              s_playing = 0;
              s_elapsed = 0;
              break;
            end
          end
        end
        v.frame_changed = (s_pos != prev);
      end
      MODE_STEP: begin
        s_playing = 0;
        s_elapsed = 0;
        if (cnt == 0) s_pos = 0;
        else begin
          nxt = (int'(s_pos) + int'(c.step_delta)) % cnt;
          if (nxt < 0) nxt += cnt;
          s_pos = nxt[5:0];
        end
      end
      MODE_PLAY: s_playing = c.play_flag;
      MODE_WRITE: begin
        s_cell[c.entry_slot] = c.entry_cell;
        s_hold[c.entry_slot] = c.entry_duration;
      end
      MODE_CLAMP: begin
        if (cnt == 0) s_pos = 0;
        else if (s_pos > cnt - 1) s_pos = cnt - 1;
      end
      default: ;
    endcase
    cols = (m_cols == 0) ? 1 : m_cols;
    if (s_pos < cnt && m_cw != 0 && m_ch != 0 && !s_cell[s_pos][12]) begin
      cell_idx = s_cell[s_pos];
      v.rect_valid = 1;
      v.rect_x = 24'((cell_idx % cols) * m_cw);
      v.rect_y = 24'((cell_idx / cols) * m_ch);
      v.rect_w = m_cw;
      v.rect_h = m_ch;
    end
    v.frame_position = s_pos;
    v.is_playing = s_playing;
    expected_views = {expected_views, v};
  endfunction

  // driver: bursts and gaps
  int gap_left = 0, burst_left = 4;
  always @(posedge clk) begin
    anim_cmd_t c;
    logic offer;
    offer = in_valid;
    if (!rst && in_valid && !in_stall) begin
      advance_player('{mode, delta_time, step_delta, play_flag, entry_slot,
                       entry_cell, entry_duration});
      n_accepted++;
      offer = 0;
    end
    if (!rst && !offer) begin
      if (gap_left > 0) gap_left--;
      else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        mode <= c.mode;
        delta_time <= c.delta_time;
        step_delta <= c.step_delta;
        play_flag <= c.play_flag;
        entry_slot <= c.entry_slot;
        entry_cell <= c.entry_cell;
        entry_duration <= c.entry_duration;
        offer = 1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end
      end
    end
    in_valid <= offer;
  end

  // receiver: own stall pattern plus long hold-offs
  int rx_cycle = 0, long_hold = 0, stall_style = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 5000 == 0) stall_style = $urandom_range(0, 3);
    if (rx_cycle == 4000 || rx_cycle == 90000) long_hold = 600;
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1;
    end else case (stall_style)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    frame_view_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result beat, position %0d", $time, frame_position);
        errors++;
      end else begin
        e = expected_views.pop_front();
        n_checked++;
        if (frame_changed) n_ticks_moved++;
        if (e.frame_position != frame_position) begin
          $display("%0t: frame_position exp %0d got %0d", $time, e.frame_position,
                   frame_position);
          errors++;
        end
        if (e.frame_changed != frame_changed) begin
          $display("%0t: frame_changed exp %0d got %0d", $time, e.frame_changed,
                   frame_changed);
          errors++;
        end
        if (e.is_playing != is_playing) begin
          $display("%0t: is_playing exp %0d got %0d", $time, e.is_playing, is_playing);
          errors++;
        end
        if (e.rect_valid != rect_valid) begin
          $display("%0t: rect_valid exp %0d got %0d", $time, e.rect_valid, rect_valid);
          errors++;
        end
        if (e.rect_x != rect_x) begin
          $display("%0t: rect_x exp %0d got %0d", $time, e.rect_x, rect_x);
          errors++;
        end
        if (e.rect_y != rect_y) begin
          $display("%0t: rect_y exp %0d got %0d", $time, e.rect_y, rect_y);
          errors++;
        end
        if (e.rect_w != rect_w) begin
          $display("%0t: rect_w exp %0d got %0d", $time, e.rect_w, rect_w);
          errors++;
        end
        if (e.rect_h != rect_h) begin
          $display("%0t: rect_h exp %0d got %0d", $time, e.rect_h, rect_h);
          errors++;
        end
      end
    end
  end

  task automatic write_regs(input logic [6:0] cnt, input logic [23:0] dflt,
                            input logic lp, input logic [11:0] cw, input logic [11:0] ch,
                            input logic [11:0] cols);
    logic [23:0] vals[6];
    vals = '{24'(cnt), dflt, 24'(lp), 24'(cw), 24'(ch), 24'(cols)};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 0;
    m_count = cnt; m_dflt = dflt; m_loop = lp; m_cw = cw; m_ch = ch; m_cols = cols;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic anim_cmd_t cmd(logic [2:0] md, logic [23:0] dt = 0,
                                    logic signed [15:0] sd = 0, logic pf = 1,
                                    logic [5:0] sl = 0, logic signed [12:0] ce = 0,
                                    logic [23:0] du = 0);
    return '{md, dt, sd, pf, sl, ce, du};
  endfunction

  function automatic anim_cmd_t random_cmd(int dur_scale);
    anim_cmd_t c;
    int r;
    c = cmd(MODE_TICK, 24'($urandom), 16'($urandom), 1'($urandom), 6'($urandom),
            13'($urandom), 24'($urandom));
    r = $urandom_range(0, 99);
    if (r < 50) begin
      c.mode = MODE_TICK;
      if ($urandom_range(0, 9) != 0) c.delta_time = $urandom_range(0, 3 * dur_scale);
    end else if (r < 62) begin
      c.mode = MODE_STEP;
      if ($urandom_range(0, 1) == 0) c.step_delta = $signed(16'($urandom_range(0, 140))) - 70;
    end else if (r < 72) begin
      c.mode = MODE_PLAY;
      c.play_flag = ($urandom_range(0, 4) != 0);
    end else if (r < 87) begin
      c.mode = MODE_WRITE;
      if ($urandom_range(0, 7) != 0) c.entry_cell = $urandom_range(0, 4096) - 1;
      if ($urandom_range(0, 7) != 0) c.entry_duration = $urandom_range(0, dur_scale);
    end else if (r < 95) c.mode = MODE_CLAMP;
    else c.mode = 3'(MODE_CLAMP) + 3'($urandom_range(1, 3));
    return c;
  endfunction

  initial begin
    int scale;
    s_pos = 0; s_elapsed = 0; s_playing = 0;
    m_count = 0; m_dflt = 0; m_loop = 1; m_cw = 0; m_ch = 0; m_cols = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    write_regs(7'd8, 24'd3, 1'b1, 12'd16, 12'd24, 12'd4);
    // fill the whole frame table so no entry is read unwritten
    for (int i = 0; i < MaxFrames; i++)
      queue_cmd(cmd(MODE_WRITE, 0, 0, 0, 6'(i), 13'(i), 24'($urandom_range(0, 4))));
    queue_cmd(cmd(MODE_WRITE, 0, 0, 0, 6'd2, -13'sd1, 24'hFFFFFF));
    queue_cmd(cmd(MODE_WRITE, 0, 0, 0, 6'd63, 13'sd4095, 24'd0));
    queue_cmd(cmd(MODE_PLAY, 0, 0, 1));
    queue_cmd(cmd(MODE_TICK, 24'd0));
    queue_cmd(cmd(MODE_TICK, 24'd5));
    queue_cmd(cmd(MODE_TICK, 24'hFFFFFF));
    queue_cmd(cmd(MODE_TICK, 24'hFFFFFF));
    queue_cmd(cmd(MODE_STEP, 0, 16'sd32767));
    queue_cmd(cmd(MODE_STEP, 0, -16'sd32768));
    queue_cmd(cmd(MODE_STEP, 0, -16'sd1));
    queue_cmd(cmd(MODE_TICK, 24'd9));
    queue_cmd(cmd(MODE_PLAY, 0, 0, 0));
    queue_cmd(cmd(MODE_PLAY, 0, 0, 1));
    queue_cmd(cmd(MODE_CLAMP));
    for (int m = 5; m < 8; m++) queue_cmd(cmd(3'(m), 24'hFFFFFF, -16'sd1));
    drain();
    // stale position: shrink the clip under the position
    write_regs(7'd2, 24'd1, 1'b0, 12'd4095, 12'd4095, 12'd0);
    queue_cmd(cmd(MODE_PLAY, 0, 0, 1));
    queue_cmd(cmd(MODE_TICK, 24'd3));
    queue_cmd(cmd(MODE_STEP, 0, 16'sd5));
    queue_cmd(cmd(MODE_CLAMP));
    drain();
    write_regs(7'd0, 24'd0, 1'b1, 12'd0, 12'd0, 12'd1);
    queue_cmd(cmd(MODE_STEP, 0, 16'sd3));
    queue_cmd(cmd(MODE_PLAY, 0, 0, 1));
    queue_cmd(cmd(MODE_TICK, 24'd100));
    queue_cmd(cmd(MODE_CLAMP));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(7'd64, 24'd4, 1'b1, 12'd32, 12'd32, 12'd8);
        1: write_regs(7'd127, 24'd0, 1'b0, 12'd4095, 12'd1, 12'd4095);
        2: write_regs(7'd1, 24'd2, 1'b1, 12'd7, 12'd9, 12'd1);
        3: write_regs(7'd16, 24'hFFFFFF, 1'b0, 12'd0, 12'd5, 12'd3);
        default: write_regs(7'($urandom_range(0, 70)), 24'($urandom_range(0, 12)),
                            1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      endcase
      scale = (ph == 3) ? 2000 : 8;
      for (int i = 0; i < 190; i++) queue_cmd(random_cmd(scale));
      drain();
    end
    $display("%0d items accepted, %0d results checked, %0d ticks moved the frame,",
             n_accepted, n_checked, n_ticks_moved);
    $display("over 11 register settings including empty, full and oversize clips");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
